// ===== rtl/core/text_console_scrollback_macros.svh =====
// assertion macros for the text console scrollback block
// used by text_console_scrollback.sv, no other dependencies
`ifndef TEXT_CONSOLE_SCROLLBACK_MACROS_SVH
`define TEXT_CONSOLE_SCROLLBACK_MACROS_SVH

// antecedent implies consequent in the same cycle
`define TCS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tcs check failed");

// antecedent implies consequent in the next cycle
`define TCS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tcs check failed");

`endif

// ===== rtl/core/tcs_pkg.sv =====
// shared types and constants of the text console scrollback block
// no dependencies
`default_nettype none

package tcs_pkg;

    typedef struct packed {
        logic [7:0] attr;
        logic [7:0] ch;
    } t_cell;

    localparam logic [7:0] TEXT_ATTR    = 8'h07;
    localparam logic [7:0] NEWLINE_CODE = 8'd10;
    localparam t_cell      BLANK_CELL   = '{attr: 8'h07, ch: 8'h00};

    localparam logic [1:0] FUNC_PUT   = 2'd0;
    localparam logic [1:0] FUNC_CLEAR = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;

endpackage

`default_nettype wire

// ===== rtl/core/tcs_cell_ram.sv =====
// single port cell memory, registered read output
// depends on tcs_pkg for the cell type
`default_nettype none

module tcs_cell_ram #(
    parameter int DEPTH = 10240,
    parameter int AW    = 14
) (
    input  wire                 i_clk,
    input  wire                 i_en,
    input  wire                 i_we,
    input  wire [AW-1:0]        i_addr,
    input  tcs_pkg::t_cell      i_wdata,
    output tcs_pkg::t_cell      o_rdata
);
    import tcs_pkg::*;

    t_cell r_mem [DEPTH];
    t_cell r_q;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_q <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_q;

endmodule

`default_nettype wire

// ===== rtl/core/text_console_scrollback.sv =====
// an item goes to the execute state, which registers its result; busy until it is done
// a clear item or a put that runs past the last buffer row then sweeps the cell memory,
// all BUFFER_ROWS*COLUMNS cells (10240 by default) with busy high, one cell a cycle
// reset starts the same sweep; the block takes no item until it ends
// results are strobed for one cycle and the receiver cannot stall
// top level; depends on tcs_pkg, tcs_cell_ram and text_console_scrollback_macros.svh
`default_nettype none
`include "text_console_scrollback_macros.svh"

module text_console_scrollback #(
    parameter int VISIBLE_ROWS = 25,
    parameter int COLUMNS      = 80,
    parameter int BUFFER_ROWS  = 128
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        start,
    output logic       busy,
    input  wire [1:0]  i_func,
    input  wire [7:0]  i_char_code,
    input  wire [4:0]  i_view_row,
    input  wire [6:0]  i_view_col,
    output logic       o_valid,
    output logic [7:0] o_read_char,
    output logic [7:0] o_read_attr,
    output logic [6:0] o_cursor_row,
    output logic [6:0] o_cursor_col,
    output logic [6:0] o_window_start,
    output logic       o_window_moved,
    output logic       o_store_cleared
);
    import tcs_pkg::*;

    localparam int CELLS = BUFFER_ROWS * COLUMNS;
    localparam int RW    = $clog2(BUFFER_ROWS);
    localparam int CW    = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int AW    = $clog2(CELLS);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_EXEC  = 2'd1;
    localparam logic [1:0] ST_CLEAR = 2'd2;

    logic [1:0]    r_state, n_state;
    logic [AW-1:0] r_clr, n_clr;
    logic [RW-1:0] r_row, n_row;
    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_win, n_win;
    logic          r_valid, n_valid;
    logic          r_moved, n_moved;
    logic          r_cleared, n_cleared;
    logic          r_show, n_show;

    logic [1:0]    r_func;
    logic [7:0]    r_code;
    logic          r_hit;
    logic [RW-1:0] r_brow;
    logic [CW-1:0] r_vcol;

    logic [RW-1:0] w_vrow_mod [32];
    logic [RW:0]   w_bsum;
    logic [RW-1:0] w_brow;
    logic          w_hit;
    logic          w_accept;

    logic          w_nl, w_step, w_wrap;
    logic [RW-1:0] w_row_nx;
    logic [CW-1:0] w_col_nx;
    logic [RW:0]   w_dist;
    logic          w_far;
    logic [RW-1:0] w_win_inc;
    logic [RW-1:0] w_row_sel;
    logic [CW-1:0] w_col_sel;
    logic [AW-1:0] w_addr;

    logic          w_mem_en, w_mem_we;
    logic [AW-1:0] w_mem_addr;
    t_cell         w_mem_wdata;
    t_cell         w_mem_rdata;

    for (genvar g = 0; g < 32; g++) begin : g_vrow_mod
        assign w_vrow_mod[g] = RW'(g % BUFFER_ROWS);
    end

    assign w_accept = start && !busy;
    assign w_hit    = (32'(i_view_row) < VISIBLE_ROWS) && (32'(i_view_col) < COLUMNS);
    assign w_bsum   = {1'b0, r_win} + {1'b0, w_vrow_mod[i_view_row]};
    assign w_brow   = (32'(w_bsum) >= BUFFER_ROWS) ? RW'(32'(w_bsum) - BUFFER_ROWS)
                                                    : w_bsum[RW-1:0];

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_func <= i_func;
            r_code <= i_char_code;
            r_hit  <= w_hit;
            r_brow <= w_brow;
            r_vcol <= CW'(i_view_col);
        end
    end

    // cursor and window update for a put
    assign w_nl      = (r_code == NEWLINE_CODE);
    assign w_step    = w_nl || (r_col == CW'(COLUMNS - 1));
    assign w_wrap    = w_step && (r_row == RW'(BUFFER_ROWS - 1));
    assign w_row_nx  = w_step ? r_row + RW'(1) : r_row;
    assign w_col_nx  = w_step ? '0 : r_col + CW'(1);
    assign w_dist    = (w_row_nx >= r_win)
                     ? ({1'b0, w_row_nx} - {1'b0, r_win})
                     : ({1'b0, w_row_nx} + (RW+1)'(BUFFER_ROWS) - {1'b0, r_win});
    assign w_far     = (32'(w_dist) >= VISIBLE_ROWS);
    assign w_win_inc = (r_win == RW'(BUFFER_ROWS - 1)) ? '0 : r_win + RW'(1);

    assign w_row_sel = (r_func == FUNC_PUT) ? r_row : r_brow;
    assign w_col_sel = (r_func == FUNC_PUT) ? r_col : r_vcol;
    assign w_addr    = AW'(32'(w_row_sel) * COLUMNS + 32'(w_col_sel));

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_row       = r_row;
        n_col       = r_col;
        n_win       = r_win;
        n_valid     = 1'b0;
        n_moved     = r_moved;
        n_cleared   = r_cleared;
        n_show      = r_show;
        w_mem_en    = 1'b0;
        w_mem_we    = 1'b0;
        w_mem_addr  = w_addr;
        w_mem_wdata = '{attr: TEXT_ATTR, ch: r_code};
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_valid   = 1'b1;
                n_moved   = 1'b0;
                n_cleared = 1'b0;
                n_show    = 1'b0;
                n_state   = ST_IDLE;
                case (r_func)
                    FUNC_PUT: begin
                        w_mem_en = !w_nl;
                        w_mem_we = !w_nl;
                        if (w_wrap) begin
                            n_row     = '0;
                            n_col     = '0;
                            n_win     = '0;
                            n_cleared = 1'b1;
                            n_clr     = '0;
                            n_state   = ST_CLEAR;
                        end else begin
                            n_row = w_row_nx;
                            n_col = w_col_nx;
                            if (w_far) begin
                                n_win   = w_win_inc;
                                n_moved = 1'b1;
                            end
                        end
                    end
                    FUNC_CLEAR: begin
                        n_row     = '0;
                        n_col     = '0;
                        n_win     = '0;
                        n_cleared = 1'b1;
                        n_clr     = '0;
                        n_state   = ST_CLEAR;
                    end
                    FUNC_READ: begin
                        w_mem_en = r_hit;
                        n_show   = r_hit;
                    end
                    default: begin
                    end
                endcase
            end
            ST_CLEAR: begin
                w_mem_en    = 1'b1;
                w_mem_we    = 1'b1;
                w_mem_addr  = r_clr;
                w_mem_wdata = BLANK_CELL;
                n_clr       = r_clr + AW'(1);
                if (r_clr == AW'(CELLS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr     <= '0;
            r_row     <= '0;
            r_col     <= '0;
            r_win     <= '0;
            r_valid   <= 1'b0;
            r_moved   <= 1'b0;
            r_cleared <= 1'b0;
            r_show    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_row     <= n_row;
            r_col     <= n_col;
            r_win     <= n_win;
            r_valid   <= n_valid;
            r_moved   <= n_moved;
            r_cleared <= n_cleared;
            r_show    <= n_show;
        end
    end

    tcs_cell_ram #(
        .DEPTH (CELLS),
        .AW    (AW)
    ) u_cell_ram (
        .i_clk   (i_clk),
        .i_en    (w_mem_en),
        .i_we    (w_mem_we),
        .i_addr  (w_mem_addr),
        .i_wdata (w_mem_wdata),
        .o_rdata (w_mem_rdata)
    );

    assign busy            = (r_state != ST_IDLE);
    assign o_valid         = r_valid;
    assign o_read_char     = r_show ? w_mem_rdata.ch : 8'd0;
    assign o_read_attr     = r_show ? w_mem_rdata.attr : 8'd0;
    assign o_cursor_row    = 7'(r_row);
    assign o_cursor_col    = 7'(r_col);
    assign o_window_start  = 7'(r_win);
    assign o_window_moved  = r_moved;
    assign o_store_cleared = r_cleared;

    `TCS_ASSERT_NXT(a_strobe_single, i_clk, i_rst_n, r_valid, !r_valid)
    `TCS_ASSERT_NXT(a_accept_exec, i_clk, i_rst_n, w_accept, r_state == ST_EXEC)
    `TCS_ASSERT_IMP(a_clear_home, i_clk, i_rst_n, r_valid && r_cleared,
                    r_row == '0 && r_col == '0 && r_win == '0 && r_state == ST_CLEAR)
    `TCS_ASSERT_IMP(a_row_bound, i_clk, i_rst_n, 1'b1, r_row <= RW'(BUFFER_ROWS - 1))

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// self-checking bench for text_console_scrollback: directed and random console traffic
// a shadow of the cell store and cursor predicts every result; depends on tcs_pkg and the rtl
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tcs_pkg::*;

    localparam int VISIBLE_ROWS = 25;
    localparam int COLUMNS      = 80;
    localparam int BUFFER_ROWS  = 128;
    localparam int CELL_COUNT   = BUFFER_ROWS * COLUMNS;
    localparam int RANDOM_ITEMS = 410;
    localparam int LIMIT_CYCLES = 30_000_000;

    localparam logic [1:0] FUNC_NOP = 2'd3;

    typedef struct packed {
        logic [7:0] rd_char;
        logic [7:0] rd_attr;
        logic [6:0] crow;
        logic [6:0] ccol;
        logic [6:0] wstart;
        logic       moved;
        logic       cleared;
    } t_console_view;

    class console_shadow;
        t_cell         cells[CELL_COUNT];
        int            crow;
        int            ccol;
        int            wstart;
        t_console_view pending_views[$];
        int            errors;
        int            checked;
        int            reads;
        int            clears;
        int            overflow_clears;
        int            wraps;
        int            moves;

        function new();
            blank_all();
            errors          = 0;
            checked         = 0;
            reads           = 0;
            clears          = 0;
            overflow_clears = 0;
            wraps           = 0;
            moves           = 0;
        endfunction

        function void blank_all();
            foreach (cells[i]) cells[i] = BLANK_CELL;
            crow   = 0;
            ccol   = 0;
            wstart = 0;
        endfunction

        function void log_command(logic [1:0] fn, logic [7:0] ch, logic [4:0] vr,
                                  logic [6:0] vc);
            t_console_view v;
            int            idx;
            v = '0;
            case (fn)
                FUNC_PUT: begin
                    if (ch == NEWLINE_CODE) begin
                        ccol = 0;
                        crow++;
                    end else begin
                        idx = crow * COLUMNS + ccol;
                        if (idx < CELL_COUNT) cells[idx] = '{attr: TEXT_ATTR, ch: ch};
                        ccol++;
                    end
                    if (ccol >= COLUMNS) begin
                        ccol = 0;
                        crow++;
                        wraps++;
                    end
                    if (crow >= BUFFER_ROWS) begin
                        blank_all();
                        v.cleared = 1'b1;
                        overflow_clears++;
                        clears++;
                    end
                    if ((crow + BUFFER_ROWS - wstart) % BUFFER_ROWS >= VISIBLE_ROWS) begin
                        wstart  = (wstart + 1) % BUFFER_ROWS;
                        v.moved = 1'b1;
                        moves++;
                    end
                end
                FUNC_CLEAR: begin
                    blank_all();
                    v.cleared = 1'b1;
                    clears++;
                end
                FUNC_READ: begin
                    reads++;
                    if (vr < VISIBLE_ROWS && vc < COLUMNS) begin
                        idx       = ((wstart + vr) % BUFFER_ROWS) * COLUMNS + vc;
                        v.rd_char = cells[idx].ch;
                        v.rd_attr = cells[idx].attr;
                    end
                end
                default: ;
            endcase
            v.crow   = 7'(crow);
            v.ccol   = 7'(ccol);
            v.wstart = 7'(wstart);
            pending_views.push_back(v);
        endfunction

        function void compare(string name, int want, int got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_report(t_console_view got);
            t_console_view want;
            if (pending_views.size() == 0) begin
                $error("result strobe with no command outstanding");
                errors++;
                return;
            end
            want = pending_views.pop_front();
            checked++;
            compare("read_char", want.rd_char, got.rd_char);
            compare("read_attr", want.rd_attr, got.rd_attr);
            compare("cursor_row", want.crow, got.crow);
            compare("cursor_col", want.ccol, got.ccol);
            compare("window_start", want.wstart, got.wstart);
            compare("window_moved", want.moved, got.moved);
            compare("store_cleared", want.cleared, got.cleared);
        endfunction
    endclass

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       start       = 1'b0;
    logic       busy;
    logic [1:0] i_func      = FUNC_NOP;
    logic [7:0] i_char_code = '0;
    logic [4:0] i_view_row  = '0;
    logic [6:0] i_view_col  = '0;
    logic       o_valid;
    logic [7:0] o_read_char;
    logic [7:0] o_read_attr;
    logic [6:0] o_cursor_row;
    logic [6:0] o_cursor_col;
    logic [6:0] o_window_start;
    logic       o_window_moved;
    logic       o_store_cleared;

    console_shadow sb = new();
    int            cycle_count = 0;
    int            items_sent  = 0;
    int            burst_left  = 0;

    text_console_scrollback #(
        .VISIBLE_ROWS(VISIBLE_ROWS),
        .COLUMNS     (COLUMNS),
        .BUFFER_ROWS (BUFFER_ROWS)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_func         (i_func),
        .i_char_code    (i_char_code),
        .i_view_row     (i_view_row),
        .i_view_col     (i_view_col),
        .o_valid        (o_valid),
        .o_read_char    (o_read_char),
        .o_read_attr    (o_read_attr),
        .o_cursor_row   (o_cursor_row),
        .o_cursor_col   (o_cursor_col),
        .o_window_start (o_window_start),
        .o_window_moved (o_window_moved),
        .o_store_cleared(o_store_cleared)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (o_valid) begin
            sb.check_report(t_console_view'{o_read_char, o_read_attr, o_cursor_row,
                o_cursor_col, o_window_start, o_window_moved, o_store_cleared});
        end
    end

    task automatic issue(input logic [1:0] fn, input logic [7:0] ch, input logic [4:0] vr,
                         input logic [6:0] vc);
        start       <= 1'b1;
        i_func      <= fn;
        i_char_code <= ch;
        i_view_row  <= vr;
        i_view_col  <= vc;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.log_command(fn, ch, vr, vc);
        items_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = $urandom_range(1, 24);
        end
    endtask

    task automatic put_char(input logic [7:0] ch);
        issue(FUNC_PUT, ch, 5'($urandom), 7'($urandom));
    endtask

    task automatic read_cell(input logic [4:0] vr, input logic [6:0] vc);
        issue(FUNC_READ, 8'($urandom), vr, vc);
    endtask

    function automatic logic [7:0] text_byte();
        logic [7:0] b;
        do b = 8'($urandom); while (b == NEWLINE_CODE);
        return b;
    endfunction

    task automatic random_segment();
        int kind;
        int n;
        int pick;
        kind = $urandom_range(0, 99);
        if (kind < 35) begin
            // run of mostly newlines with some text bytes, to scroll the window and reach the last buffer row
            n = $urandom_range(20, 60);
            repeat (n) begin
                if ($urandom_range(0, 4) == 0) put_char(text_byte());
                else put_char(NEWLINE_CODE);
            end
        end else if (kind < 50) begin
            n = $urandom_range(COLUMNS - 10, COLUMNS + 15);
            repeat (n) put_char(text_byte());
        end else if (kind < 70) begin
            n = $urandom_range(4, 16);
            repeat (n) begin
                if ($urandom_range(0, 5) == 0)
                    read_cell(5'($urandom), 7'($urandom));
                else if ($urandom_range(0, 3) == 0)
                    read_cell(5'($urandom_range(0, VISIBLE_ROWS - 1)),
                              7'($urandom_range(0, COLUMNS - 1)));
                else
                    read_cell(5'($urandom_range(0, VISIBLE_ROWS - 1)),
                              7'($urandom_range(0, 15)));
            end
        end else begin
            n = $urandom_range(5, 20);
            repeat (n) begin
                pick = $urandom_range(0, 99);
                if (pick < 50)
                    put_char(8'($urandom));
                else if (pick < 85)
                    read_cell(5'($urandom), 7'($urandom));
                else if (pick < 96)
                    issue(FUNC_NOP, 8'($urandom), 5'($urandom), 7'($urandom));
                else
                    issue(FUNC_CLEAR, 8'($urandom), 5'($urandom), 7'($urandom));
            end
        end
    endtask

    initial begin
        int directed_count;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        burst_left = $urandom_range(1, 24);

        read_cell(5'd0, 7'd0);
        read_cell(5'(VISIBLE_ROWS - 1), 7'(COLUMNS - 1));
        read_cell(5'(VISIBLE_ROWS), 7'd0);
        read_cell(5'h1F, 7'h7F);
        read_cell(5'd0, 7'(COLUMNS));
        put_char(8'h00);
        put_char(8'hFF);
        put_char(8'h41);
        put_char(NEWLINE_CODE);
        put_char(NEWLINE_CODE + 8'd1);
        read_cell(5'd0, 7'd0);
        read_cell(5'd0, 7'd1);
        read_cell(5'd0, 7'd2);
        read_cell(5'd1, 7'd0);
        issue(FUNC_NOP, 8'hFF, 5'h1F, 7'h7F);
        issue(FUNC_CLEAR, 8'hFF, 5'h1F, 7'h7F);
        read_cell(5'd0, 7'd1);
        read_cell(5'd1, 7'd0);
        put_char(8'h7E);
        issue(FUNC_READ, NEWLINE_CODE, 5'd0, 7'd0);
        directed_count = items_sent;

        while (items_sent < directed_count + RANDOM_ITEMS) random_segment();

        start <= 1'b0;
        while (sb.pending_views.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("covered %0d commands with %0d reads and %0d column wraps",
                 items_sent, sb.reads, sb.wraps);
        $display("store clears: %0d (%0d from running past the last row), window advances: %0d",
                 sb.clears, sb.overflow_clears, sb.moves);
        if (sb.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
